### sv/assert_macros.svh
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error("fail");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

### sv/tld_pkg.sv
// types and constants of the terminal line discipline
`timescale 1ns / 1ps
package tld_pkg;
	localparam int STORE_DEPTH = 1024;
	localparam logic [2:0] MODE_RX = 3'd0;
	localparam logic [2:0] MODE_WR = 3'd1;
	localparam logic [2:0] MODE_RD = 3'd2;
	localparam logic [2:0] MODE_DRAIN = 3'd3;
	localparam logic [2:0] MODE_FLUSH = 3'd4;
	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_INVALID = 2'd3;
	localparam logic [2:0] REG_IFLAG = 3'd0;
	localparam logic [2:0] REG_LFLAG = 3'd1;
	localparam logic [2:0] REG_OFLAG = 3'd2;
	localparam logic [2:0] REG_ERASE = 3'd3;
	localparam logic [2:0] REG_INTR = 3'd4;
	localparam logic [2:0] REG_QUIT = 3'd5;
	localparam logic [2:0] REG_SUSP = 3'd6;
	localparam logic [7:0] CH_CR = 8'h0d;
	localparam logic [7:0] CH_NL = 8'h0a;
	localparam logic [7:0] CH_BS = 8'h08;
	localparam logic [7:0] CH_SP = 8'h20;
	localparam logic [7:0] CH_CARET = 8'h5e;
	localparam logic [7:0] CARET_OFS = 8'd64;
	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] data_in;
	} tld_req_t;
	typedef struct packed {
		logic [1:0] status;
		logic [7:0] data_out;
		logic end_of_read;
		logic [1:0] signal_raised;
		logic input_ready;
		logic output_space;
		logic output_pending;
	} tld_rsp_t;
	// request from the control unit to the output ring
	typedef struct packed {
		logic put;
		logic [7:0] byte_val;
		logic flush;
		logic pop;
	} tld_oreq_t;
	function automatic logic [7:0] post_map(input logic [7:0] c, input logic [4:0] of);
		logic [7:0] r;
		r = c;
		if (of[0] && c == CH_CR && of[3]) r = CH_NL;
		else if (of[0] && of[4] && c >= 8'h61 && c <= 8'h7a) r = c - 8'h20;
		return r;
	endfunction
endpackage

### sv/terminal_line_discipline.sv
// top level of the terminal line discipline
`timescale 1ns / 1ps
`include "assert_macros.svh"
// A request is taken when start is high and busy is low; its single result
// shows on rsp for one cycle with done high and cannot be held off. A request
// goes through the execute and finish states before the next can be taken,
// and a received byte that echoes also passes through the echo state, which
// writes its echo bytes into the output ring one at a time, since every store
// byte goes through the one write port of the output ring. Reads take their
// data from the registered memory output. There is no clearing pass: positions reset to 0.
module terminal_line_discipline import tld_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input tld_req_t req,
	output logic done,
	output tld_rsp_t rsp,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [7:0] cfg_data
);
	localparam int AW = $clog2(STORE_DEPTH);
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001, S_EXEC = 4'b0010, S_ECHO = 4'b0100, S_FIN = 4'b1000
	} state_t;
	state_t st_q;
	tld_req_t r_q;
	logic [4:0] iflag_q, oflag_q;
	logic [3:0] lflag_q;
	logic [7:0] erase_q, intr_q, quit_q, susp_q;
	logic [AW-1:0] cwp_q, crp_q, lsp_q;
	logic [9:0] lines_q;
	logic [7:0] cmem [2**AW];
	logic [7:0] crd;
	logic cwe;
	logic [7:0] cwd;
	// echo queue: up to three bytes
	logic [7:0] eb_q [3];
	logic [1:0] en_q;
	logic [1:0] ei_q;
	logic nl_pending;
	logic [1:0] status_q, sig_q;
	logic [7:0] dout_q;
	logic eor_q;
	tld_oreq_t oreq;
	logic [AW:0] oused;
	logic [7:0] ord;
	localparam logic [AW:0] CAP = (AW+1)'(STORE_DEPTH - 1);
	logic [AW:0] ofree;
	logic [AW-1:0] cused;
	logic cfull, canon;
	logic [7:0] c0, c1, c2;
	assign ofree = CAP - oused;
	assign cused = cwp_q - crp_q;
	assign cfull = cused == AW'(STORE_DEPTH - 1);
	assign canon = lflag_q[0];
	assign busy = st_q != S_IDLE;
	assign cfg_ready = st_q == S_IDLE && !start;
	// cooked memory, one write port and one registered read port
	always_ff @(posedge clk) begin
		if (cwe) cmem[cwp_q] <= cwd;
		crd <= cmem[crp_q];
	end
	// input cooking chain
	always_comb begin
		c0 = iflag_q[0] ? {1'b0, r_q.data_in[6:0]} : r_q.data_in;
		c1 = (iflag_q[1] && c0 >= 8'h41 && c0 <= 8'h5a) ? c0 + 8'h20 : c0;
		c2 = c1;
		if (c1 == CH_CR && iflag_q[3]) c2 = CH_NL;
		else if (c1 == CH_NL && iflag_q[4]) c2 = CH_CR;
	end
	logic ctl, spc;
	assign ctl = c2 < 8'd32 || c2 == 8'd127;
	assign spc = (c2 >= 8'd9 && c2 <= 8'd13) || c2 == CH_SP;
	always_comb begin
		oreq = '0;
		cwe = 1'b0;
		cwd = c2;
		if (st_q == S_EXEC && r_q.mode == MODE_WR && ofree != 0) begin
			if (!(oflag_q[0] && r_q.data_in == CH_CR && oflag_q[2])) begin
				if (!(oflag_q[0] && r_q.data_in == CH_NL && oflag_q[1])) begin
					oreq.put = 1'b1;
					oreq.byte_val = post_map(r_q.data_in, oflag_q);
				end else if (ofree >= 2) begin
					oreq.put = 1'b1;
					oreq.byte_val = CH_CR;
				end
			end
		end
		if (st_q == S_ECHO && nl_pending) begin
			oreq.put = 1'b1;
			oreq.byte_val = CH_NL;
		end else if (st_q == S_ECHO && ei_q < en_q && ofree != 0) begin
			if (eb_q[ei_q] == CH_NL && oflag_q[0] && oflag_q[1]) begin
				if (ofree >= 2) begin
					oreq.put = 1'b1;
					oreq.byte_val = CH_CR;
				end
			end else if (!(oflag_q[0] && eb_q[ei_q] == CH_CR && oflag_q[2])) begin
				oreq.put = 1'b1;
				oreq.byte_val = post_map(eb_q[ei_q], oflag_q);
			end
		end
		if (st_q == S_FIN && r_q.mode == MODE_WR && status_q == ST_DONE && eor_q) begin
			oreq.put = 1'b1;
			oreq.byte_val = CH_NL;
		end
		if (st_q == S_EXEC && r_q.mode == MODE_DRAIN && oused != 0) oreq.pop = 1'b1;
		if (st_q == S_EXEC && r_q.mode == MODE_FLUSH &&
		    (r_q.data_in == 8'd1 || r_q.data_in == 8'd2)) oreq.flush = 1'b1;
		if (st_q == S_EXEC && r_q.mode == MODE_RX && !cfull && !(c1 == CH_CR && iflag_q[2])
		    && !(canon && c2 == erase_q)
		    && !(lflag_q[1] && (c2 == intr_q || c2 == quit_q || c2 == susp_q)))
			cwe = 1'b1;
	end
	tld_out_ring #(.AW(AW)) u_out (
		.clk(clk), .arst_n(arst_n), .oreq(oreq), .used(oused), .rd_data(ord)
	);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			r_q <= '0;
			iflag_q <= 5'd8; lflag_q <= 4'd15; oflag_q <= 5'd3;
			erase_q <= 8'd127; intr_q <= 8'd3; quit_q <= 8'd28; susp_q <= 8'd26;
			cwp_q <= '0; crp_q <= '0; lsp_q <= '0; lines_q <= '0;
			eb_q <= '{default: 8'h00};
			en_q <= '0; ei_q <= '0; nl_pending <= 1'b0;
			status_q <= ST_DONE; sig_q <= '0; dout_q <= '0; eor_q <= 1'b0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (st_q)
				S_IDLE: begin
					if (start) begin
						r_q <= req;
						st_q <= S_EXEC;
					end else if (cfg_valid && cfg_index <= REG_SUSP) begin
						unique case (cfg_index)
							REG_IFLAG: iflag_q <= cfg_data[4:0];
							REG_LFLAG: lflag_q <= cfg_data[3:0];
							REG_OFLAG: oflag_q <= cfg_data[4:0];
							REG_ERASE: erase_q <= cfg_data;
							REG_INTR: intr_q <= cfg_data;
							REG_QUIT: quit_q <= cfg_data;
							default: susp_q <= cfg_data;
						endcase
						lines_q <= '0;
						lsp_q <= cwp_q;
					end
				end
				S_EXEC: begin
					status_q <= ST_DONE; sig_q <= '0; dout_q <= '0; eor_q <= 1'b0;
					en_q <= '0; ei_q <= '0;
					st_q <= S_FIN;
					unique case (r_q.mode)
						MODE_RX: begin
							if (cfull) status_q <= ST_FULL;
							else if (c1 == CH_CR && iflag_q[2]) begin
							end else if (canon && c2 == erase_q) begin
								if (cwp_q != lsp_q && cwp_q != crp_q) begin
									cwp_q <= cwp_q - 1'b1;
									if (lflag_q[2]) begin
										eb_q[0] <= CH_BS; eb_q[1] <= CH_SP; eb_q[2] <= CH_BS;
										en_q <= 2'd3; st_q <= S_ECHO;
									end
								end
							end else if (lflag_q[1] && c2 == intr_q) sig_q <= 2'd1;
							else if (lflag_q[1] && c2 == quit_q) sig_q <= 2'd2;
							else if (lflag_q[1] && c2 == susp_q) sig_q <= 2'd3;
							else begin
								cwp_q <= cwp_q + 1'b1;
								if (canon && c2 == CH_NL) begin
									lsp_q <= cwp_q + 1'b1;
									if (lines_q < 10'd1023) lines_q <= lines_q + 1'b1;
								end
								if (lflag_q[2] && ofree != 0) begin
									st_q <= S_ECHO;
									if (ctl && !spc && lflag_q[3]) begin
										eb_q[0] <= CH_CARET; eb_q[1] <= c2 + CARET_OFS;
										en_q <= 2'd2;
									end else begin
										eb_q[0] <= c2; en_q <= 2'd1;
									end
								end
							end
						end
						MODE_WR: begin
							if (ofree == 0) status_q <= ST_FULL;
							else if (oflag_q[0] && r_q.data_in == CH_NL && oflag_q[1]) begin
								if (ofree < 2) status_q <= ST_FULL;
								else eor_q <= 1'b1;
							end
						end
						MODE_RD: begin
							if (canon ? lines_q == 0 : cused == 0) status_q <= ST_EMPTY;
							else begin
								crp_q <= crp_q + 1'b1;
								eor_q <= 1'b1;
							end
						end
						MODE_DRAIN: if (oused == 0) status_q <= ST_EMPTY;
						MODE_FLUSH: begin
							if (r_q.data_in > 8'd2) status_q <= ST_INVALID;
							else if (r_q.data_in != 8'd1) begin
								cwp_q <= '0; crp_q <= '0; lsp_q <= '0; lines_q <= '0;
							end
						end
						default: status_q <= ST_INVALID;
					endcase
				end
				S_ECHO: begin
					if (nl_pending) nl_pending <= 1'b0;
					else if (ei_q < en_q && eb_q[ei_q] == CH_NL && oflag_q[0] && oflag_q[1]
					         && ofree >= 2)
						nl_pending <= 1'b1;
					if (nl_pending || !(ei_q < en_q && eb_q[ei_q] == CH_NL && oflag_q[0]
					    && oflag_q[1] && ofree >= 2)) begin
						if (ei_q + 1'b1 >= en_q) st_q <= S_FIN;
						ei_q <= ei_q + 1'b1;
					end
				end
				S_FIN: begin
					st_q <= S_IDLE;
					done <= 1'b1;
					if (r_q.mode == MODE_RD && status_q == ST_DONE) begin
						dout_q <= crd;
						if (canon) begin
							eor_q <= crd == CH_NL;
							if (crd == CH_NL && lines_q != 0) lines_q <= lines_q - 1'b1;
						end else eor_q <= cused == 0;
					end else if (r_q.mode == MODE_DRAIN && status_q == ST_DONE) dout_q <= ord;
					else if (r_q.mode == MODE_WR) eor_q <= 1'b0;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
	// nl expansion in echo: cr written above, nl written while pending
	assign rsp.status = status_q;
	assign rsp.data_out = dout_q;
	assign rsp.end_of_read = eor_q;
	assign rsp.signal_raised = sig_q;
	assign rsp.input_ready = canon ? lines_q != 0 : cused != 0;
	assign rsp.output_space = ofree != 0;
	assign rsp.output_pending = oused != 0;
	`ASSERT_IMPL(a_done_idle, clk, arst_n, !done || st_q == S_IDLE)
	`ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy)
	`ASSERT_IMPL(a_cap, clk, arst_n, oused <= CAP)
endmodule

### sv/tld_out_ring.sv
// output ring store with synchronous memory, one write port and one read port
`timescale 1ns / 1ps
module tld_out_ring import tld_pkg::*; #(
	parameter int AW = 10
) (
	input logic clk,
	input logic arst_n,
	input tld_oreq_t oreq,
	output logic [AW:0] used,
	output logic [7:0] rd_data
);
	logic [7:0] mem [2**AW];
	logic [AW-1:0] wp_q, rp_q;
	always_ff @(posedge clk) begin
		if (oreq.put) mem[wp_q] <= oreq.byte_val;
		rd_data <= mem[rp_q];
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else if (oreq.flush) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			if (oreq.put) wp_q <= wp_q + 1'b1;
			if (oreq.pop) rp_q <= rp_q + 1'b1;
		end
	end
	assign used = {1'b0, wp_q - rp_q};
endmodule

### tb/tld_checker.sv
// checker for the terminal line discipline: predicts each result and compares
`timescale 1ns / 1ps
module tld_checker import tld_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input tld_req_t req,
	input logic done,
	input tld_rsp_t rsp,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [7:0] cfg_data,
	output int fail_count,
	output int pending,
	output int result_count
);
	// predicted line discipline state
	logic [7:0] line_buf [1024];
	logic [7:0] tx_buf [1024];
	logic [9:0] lb_wr, lb_rd, line_mark, tx_wr, tx_rd;
	int unsigned line_count;
	logic [4:0] iflg, oflg;
	logic [3:0] lflg;
	logic [7:0] erase_ch, intr_ch, quit_ch, susp_ch;
	tld_rsp_t expected_rsp [$];

	function automatic int unsigned tx_room();
		logic [9:0] used;
		used = tx_wr - tx_rd;
		return 1023 - used;
	endfunction

	function automatic void tx_push(logic [7:0] c);
		tx_buf[tx_wr] = c;
		tx_wr = tx_wr + 10'd1;
	endfunction

	// output post-processing of one byte; returns the status
	function automatic logic [1:0] tx_post(logic [7:0] c);
		int unsigned room;
		room = tx_room();
		if (room == 0) return ST_FULL;
		if (oflg[0]) begin
			if (c == CH_NL) begin
				if (oflg[1]) begin
					if (room < 2) return ST_FULL;
					tx_push(CH_CR);
				end
			end else if (c == CH_CR) begin
				if (oflg[2]) return ST_DONE;
				if (oflg[3]) c = CH_NL;
			end else if (oflg[4] && c >= "a" && c <= "z") begin
				c = c - 8'h20;
			end
		end
		tx_push(c);
		return ST_DONE;
	endfunction

	function automatic void echo_pred(logic [7:0] c);
		logic ctl, spc;
		logic [1:0] st;
		ctl = (c < 8'd32) || (c == 8'd127);
		spc = (c >= 8'd9 && c <= 8'd13) || (c == CH_SP);
		if (ctl && !spc && lflg[3]) begin
			st = tx_post(CH_CARET);
			st = tx_post(c + CARET_OFS);
		end else begin
			st = tx_post(c);
		end
	endfunction

	// cook one received byte
	function automatic logic [1:0] cook_char(logic [7:0] c, output logic [1:0] sig);
		logic [1:0] st;
		sig = 2'd0;
		if (lb_wr + 10'd1 == lb_rd) return ST_FULL;
		if (iflg[0]) c[7] = 1'b0;
		if (iflg[1] && c >= "A" && c <= "Z") c = c + 8'h20;
		if (c == CH_CR) begin
			if (iflg[2]) return ST_DONE;
			if (iflg[3]) c = CH_NL;
		end else if (c == CH_NL && iflg[4]) begin
			c = CH_CR;
		end
		if (lflg[0] && c == erase_ch) begin
			if (lb_wr != line_mark && lb_wr != lb_rd) begin
				lb_wr = lb_wr - 10'd1;
				if (lflg[2]) begin
					st = tx_post(CH_BS);
					st = tx_post(CH_SP);
					st = tx_post(CH_BS);
				end
			end
			return ST_DONE;
		end
		if (lflg[1]) begin
			if (c == intr_ch) begin
				sig = 2'd1;
				return ST_DONE;
			end
			if (c == quit_ch) begin
				sig = 2'd2;
				return ST_DONE;
			end
			if (c == susp_ch) begin
				sig = 2'd3;
				return ST_DONE;
			end
		end
		if (lflg[2] && tx_room() != 0) echo_pred(c);
		line_buf[lb_wr] = c;
		lb_wr = lb_wr + 10'd1;
		if (lflg[0] && c == CH_NL) begin
			line_mark = lb_wr;
			if (line_count < 1023) line_count++;
		end
		return ST_DONE;
	endfunction

	function automatic logic input_avail();
		if (lflg[0]) return line_count > 0;
		return lb_wr != lb_rd;
	endfunction

	function automatic tld_rsp_t predict(tld_req_t r);
		tld_rsp_t e;
		logic [1:0] sig;
		e = '0;
		case (r.mode)
			MODE_RX: begin
				e.status = cook_char(r.data_in, sig);
				e.signal_raised = sig;
			end
			MODE_WR: e.status = tx_post(r.data_in);
			MODE_RD: begin
				if (!input_avail()) begin
					e.status = ST_EMPTY;
				end else begin
					e.data_out = line_buf[lb_rd];
					lb_rd = lb_rd + 10'd1;
					if (lflg[0]) begin
						if (e.data_out == CH_NL) begin
							e.end_of_read = 1'b1;
							if (line_count > 0) line_count--;
						end
					end else if (lb_rd == lb_wr) begin
						e.end_of_read = 1'b1;
					end
				end
			end
			MODE_DRAIN: begin
				if (tx_wr == tx_rd) begin
					e.status = ST_EMPTY;
				end else begin
					e.data_out = tx_buf[tx_rd];
					tx_rd = tx_rd + 10'd1;
				end
			end
			MODE_FLUSH: begin
				if (r.data_in > 8'd2) begin
					e.status = ST_INVALID;
				end else begin
					if (r.data_in != 8'd1) begin
						lb_wr = '0;
						lb_rd = '0;
						line_mark = '0;
						line_count = 0;
					end
					if (r.data_in != 8'd0) begin
						tx_wr = '0;
						tx_rd = '0;
					end
				end
			end
			default: e.status = ST_INVALID;
		endcase
		e.input_ready = input_avail();
		e.output_space = tx_room() != 0;
		e.output_pending = tx_wr != tx_rd;
		return e;
	endfunction

	assign pending = expected_rsp.size();

	always @(posedge clk or negedge arst_n) begin
		tld_rsp_t e;
		if (!arst_n) begin
			lb_wr = '0;
			lb_rd = '0;
			line_mark = '0;
			tx_wr = '0;
			tx_rd = '0;
			line_count = 0;
			iflg = 5'd8;
			lflg = 4'd15;
			oflg = 5'd3;
			erase_ch = 8'd127;
			intr_ch = 8'd3;
			quit_ch = 8'd28;
			susp_ch = 8'd26;
			fail_count <= 0;
			result_count <= 0;
			expected_rsp.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_IFLAG: iflg = cfg_data[4:0];
					REG_LFLAG: lflg = cfg_data[3:0];
					REG_OFLAG: oflg = cfg_data[4:0];
					REG_ERASE: erase_ch = cfg_data;
					REG_INTR: intr_ch = cfg_data;
					REG_QUIT: quit_ch = cfg_data;
					REG_SUSP: susp_ch = cfg_data;
					default: ;
				endcase
				if (cfg_index <= REG_SUSP) begin
					line_count = 0;
					line_mark = lb_wr;
				end
			end
			if (start && !busy) expected_rsp.push_back(predict(req));
			if (done) begin
				result_count <= result_count + 1;
				if (expected_rsp.size() == 0) begin
					$error("result with no request outstanding");
					fail_count <= fail_count + 1;
				end else begin
					e = expected_rsp.pop_front();
					if (rsp != e) begin
						fail_count <= fail_count + 1;
						if (rsp.status != e.status)
							$error("status exp %0d got %0d", e.status, rsp.status);
						if (rsp.data_out != e.data_out)
							$error("data_out exp %0d got %0d", e.data_out, rsp.data_out);
						if (rsp.end_of_read != e.end_of_read)
							$error("end_of_read exp %0d got %0d", e.end_of_read,
								rsp.end_of_read);
						if (rsp.signal_raised != e.signal_raised)
							$error("signal_raised exp %0d got %0d", e.signal_raised,
								rsp.signal_raised);
						if (rsp.input_ready != e.input_ready)
							$error("input_ready exp %0d got %0d", e.input_ready,
								rsp.input_ready);
						if (rsp.output_space != e.output_space)
							$error("output_space exp %0d got %0d", e.output_space,
								rsp.output_space);
						if (rsp.output_pending != e.output_pending)
							$error("output_pending exp %0d got %0d", e.output_pending,
								rsp.output_pending);
					end
				end
			end
		end
	end
endmodule

### tb/tb_terminal_line_discipline.sv
// testbench top of the terminal line discipline: stimulus and verdict
`timescale 1ns / 1ps
module tb_terminal_line_discipline import tld_pkg::*; ();

	localparam int IDLE_LIMIT = 5000;
	localparam int SETTLE = 12;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	tld_req_t req = '0;
	logic done;
	tld_rsp_t rsp;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;
	int fail_count, pending, result_count;
	int sent = 0;
	int idle_cycles = 0;
	// burst shaping for the request side
	int burst_left = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	terminal_line_discipline uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	tld_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.done(done), .rsp(rsp), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .fail_count(fail_count),
		.pending(pending), .result_count(result_count)
	);

	// watchdog: any handshake or result counts as progress
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog expired with %0d results outstanding", pending);
			$display("FAIL");
			$finish;
		end
	end

	// one request; start stays high into the next request of a burst
	task automatic send(logic [2:0] m, logic [7:0] d);
		int gap;
		start <= 1'b1;
		req <= '{mode: m, data_in: d};
		@(posedge clk);
		while (busy) @(posedge clk);
		sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			// end of burst: drop start for a random gap, sometimes none
			burst_left = $urandom_range(0, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// registers are only written with the block idle
	task automatic set_reg(logic [2:0] idx, logic [7:0] val);
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_all(logic [4:0] ifl, logic [3:0] lfl, logic [4:0] ofl,
			logic [7:0] er, logic [7:0] it, logic [7:0] qu, logic [7:0] su);
		set_reg(REG_IFLAG, {3'b0, ifl});
		set_reg(REG_LFLAG, {4'b0, lfl});
		set_reg(REG_OFLAG, {3'b0, ofl});
		set_reg(REG_ERASE, er);
		set_reg(REG_INTR, it);
		set_reg(REG_QUIT, qu);
		set_reg(REG_SUSP, su);
	endtask

	// mostly typed text and line ends, with control keys and noise mixed in
	function automatic logic [7:0] typed_char(logic [7:0] er, logic [7:0] it,
			logic [7:0] qu, logic [7:0] su);
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 8'($urandom_range(32, 126));
		if (r < 65) return CH_NL;
		if (r < 70) return CH_CR;
		if (r < 78) return er;
		if (r < 81) return it;
		if (r < 83) return qu;
		if (r < 85) return su;
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic random_phase(int n, logic [7:0] er, logic [7:0] it,
			logic [7:0] qu, logic [7:0] su);
		int r;
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < 48) send(MODE_RX, typed_char(er, it, qu, su));
			else if (r < 60) send(MODE_WR, typed_char(er, it, qu, su));
			else if (r < 76) send(MODE_RD, 8'($urandom_range(0, 255)));
			else if (r < 96) send(MODE_DRAIN, 8'($urandom_range(0, 255)));
			else if (r < 98) send(MODE_FLUSH, 8'($urandom_range(0, 3)));
			else send(3'($urandom_range(5, 7)), 8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		logic [4:0] ifl, ofl;
		logic [3:0] lfl;
		logic [7:0] er, it, qu, su;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset settings: cr mapping, reads, erase, signals, caret echo
		send(MODE_RX, "A");
		send(MODE_RX, CH_CR);
		send(MODE_RD, 8'h00);
		send(MODE_RD, 8'h00);
		send(MODE_RD, 8'h00);
		send(MODE_RX, "b");
		send(MODE_RX, 8'd127);
		send(MODE_RX, 8'd127);
		send(MODE_RX, 8'd3);
		send(MODE_RX, 8'd28);
		send(MODE_RX, 8'd26);
		send(MODE_RX, 8'h01);
		send(MODE_WR, CH_NL);
		send(MODE_WR, CH_CR);
		send(MODE_DRAIN, 8'hff);
		send(MODE_FLUSH, 8'd3);
		send(MODE_FLUSH, 8'd255);
		send(3'd5, 8'h00);
		send(3'd7, 8'hff);
		send(MODE_FLUSH, 8'd0);
		send(MODE_FLUSH, 8'd1);
		send(MODE_FLUSH, 8'd2);
		send(MODE_DRAIN, 8'h00);

		// every flag set, erase on 255 and quit on del: del raises quit, cr dropped on write
		set_all(5'h1f, 4'hf, 5'h1f, 8'hff, 8'h00, 8'h7f, 8'hfe);
		send(MODE_RX, 8'd127);
		send(MODE_RX, 8'hc1);
		send(MODE_WR, CH_CR);
		send(MODE_WR, "z");

		// raw mode with caret echo, no signals: overfill both stores so echo
		// gets dropped and further bytes and writes are refused
		set_all(5'h00, 4'hc, 5'h03, 8'h7f, 8'h03, 8'h1c, 8'h1a);
		repeat (1026) send(MODE_RX, ($urandom_range(0, 1) == 1) ?
			8'($urandom_range(0, 31)) : 8'($urandom_range(0, 255)));
		send(MODE_WR, CH_NL);
		send(MODE_WR, "x");
		repeat (3) send(MODE_DRAIN, 8'h00);
		send(MODE_WR, CH_NL);
		send(MODE_WR, CH_NL);
		send(MODE_FLUSH, 8'd2);

		// random phases across settings, zero and defaults included
		for (int p = 0; p < 7; p++) begin
			if (p == 0) begin
				ifl = 5'h00; lfl = 4'h0; ofl = 5'h00;
				er = 8'h00; it = 8'h00; qu = 8'h00; su = 8'h00;
			end else if (p == 1) begin
				ifl = 5'h08; lfl = 4'hf; ofl = 5'h03;
				er = 8'd127; it = 8'd3; qu = 8'd28; su = 8'd26;
			end else begin
				ifl = 5'($urandom_range(0, 31));
				lfl = 4'($urandom_range(0, 15)) | 4'h1;
				ofl = 5'($urandom_range(0, 31));
				er = ($urandom_range(0, 1) == 1) ? 8'd127 : 8'($urandom_range(0, 255));
				it = 8'($urandom_range(0, 255));
				qu = 8'($urandom_range(0, 31));
				su = 8'($urandom_range(128, 255));
			end
			set_all(ifl, lfl, ofl, er, it, qu, su);
			random_phase(5, er, it, qu, su);
		end

		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		$display("ran %0d requests over 10 register settings, %0d results checked",
			sent, result_count);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

### files.f
+incdir+sv
sv/tld_pkg.sv
sv/tld_out_ring.sv
sv/terminal_line_discipline.sv
tb/tld_checker.sv
tb/tb_terminal_line_discipline.sv
